// File: rtl/bcdec_pkg.sv
// ----------------------------------------------------------------------------
// bcdec_pkg
// Shared types, register codes and small arithmetic helpers for the BC1/BC2/BC3
// block decoder.
// ----------------------------------------------------------------------------
package bcdec_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 15;

   // Configuration register indexes.
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FORMAT_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   // Format codes. Code three decodes as BC3.
   typedef enum logic [1:0] {
      FMT_BC1      = 2'd0,
      FMT_BC2      = 2'd1,
      FMT_BC3      = 2'd2,
      FMT_BC3_ALT  = 2'd3
   } format_type;

   localparam logic [14:0] ImageSizeReset = 15'd4096;

   // Reciprocals for exact truncating division over the value ranges used here.
   localparam logic [10:0] Recip3  = 11'd1366;   // shift 12, exact below 2048
   localparam logic [11:0] Recip5  = 12'd3277;   // shift 14, exact below 16384
   localparam logic [11:0] Recip7  = 12'd2341;   // shift 14, exact below 5461
   localparam logic [13:0] Recip31 = 14'd8457;   // shift 18, exact below 11397
   localparam logic [14:0] Recip63 = 15'd16645;  // shift 20, exact below 17772

   typedef struct packed {
      logic [11:0] block_col;
      logic [11:0] block_row;
      logic [63:0] alpha_word;
      logic [63:0] colour_word;
   } req_type;

   typedef struct packed {
      logic [13:0] texel_x;
      logic [13:0] texel_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        inside_image;
      logic        last_texel;
   } rsp_type;

   typedef struct packed {
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0]  data;
   } csr_type;

   // Per-block decode data held while the sixteen texels are emitted.
   typedef struct packed {
      logic [2:0][7:0]  ep0;        // widened endpoint 0, red/green/blue
      logic [2:0][7:0]  ep1;        // widened endpoint 1
      logic             three_col;  // BC1 three-colour mode
      logic [7:0][7:0]  apal;       // BC3 alpha palette
   } pal_type;

   // (v*255+15)/31
   function automatic logic [7:0] widen5(input logic [4:0] v);
      logic [12:0] x;
      logic [26:0] p;
      x = 13'(v) * 13'd255 + 13'd15;
      p = 27'(x) * 27'(Recip31);
      return p[25:18];
   endfunction

   // (v*255+31)/63
   function automatic logic [7:0] widen6(input logic [5:0] v);
      logic [13:0] x;
      logic [28:0] p;
      x = 14'(v) * 14'd255 + 14'd31;
      p = 29'(x) * 29'(Recip63);
      return p[27:20];
   endfunction

   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'(Recip3);
      return p[19:12];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'(Recip5);
      return p[21:14];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'(Recip7);
      return p[21:14];
   endfunction

endpackage

// File: rtl/bcdec_if.sv
// ----------------------------------------------------------------------------
// bcdec interfaces
// Valid/ready channels for block requests, texel responses and register writes.
// ----------------------------------------------------------------------------
interface bcdec_req_if;
   logic               valid;
   logic               ready;
   bcdec_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bcdec_rsp_if;
   logic               valid;
   logic               ready;
   bcdec_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bcdec_csr_if;
   logic               valid;
   logic               ready;
   bcdec_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bcdec_palette.sv
// ----------------------------------------------------------------------------
// bcdec_palette
// Widens the colour endpoints and builds the BC3 alpha palette for one block.
// ----------------------------------------------------------------------------
module bcdec_palette (
   input  logic [63:0]        alpha_word,
   input  logic [31:0]        endpoints,
   input  logic               punch,
   output bcdec_pkg::pal_type pal
);

   logic [15:0] e0;
   logic [15:0] e1;
   logic [7:0]  a0;
   logic [7:0]  a1;

   assign e0 = endpoints[15:0];
   assign e1 = endpoints[31:16];
   assign a0 = alpha_word[7:0];
   assign a1 = alpha_word[15:8];

   always_comb begin
      pal.ep0[0] = bcdec_pkg::widen5(e0[15:11]);
      pal.ep0[1] = bcdec_pkg::widen6(e0[10:5]);
      pal.ep0[2] = bcdec_pkg::widen5(e0[4:0]);
      pal.ep1[0] = bcdec_pkg::widen5(e1[15:11]);
      pal.ep1[1] = bcdec_pkg::widen6(e1[10:5]);
      pal.ep1[2] = bcdec_pkg::widen5(e1[4:0]);
      pal.three_col = punch && (e0 <= e1);

      pal.apal[0] = a0;
      pal.apal[1] = a1;
      if (a0 > a1) begin
         for (int k = 1; k <= 6; k++) begin
            pal.apal[k+1] = bcdec_pkg::div7(11'(7 - k) * 11'(a0) + 11'(k) * 11'(a1));
         end
      end else begin
         for (int k = 1; k <= 4; k++) begin
            pal.apal[k+1] = bcdec_pkg::div5(11'(5 - k) * 11'(a0) + 11'(k) * 11'(a1));
         end
         pal.apal[6] = 8'd0;
         pal.apal[7] = 8'd255;
      end
   end

endmodule

// File: rtl/bc1_bc2_bc3_block_decoder.sv
// ----------------------------------------------------------------------------
// bc1_bc2_bc3_block_decoder
// Decodes one compressed 4x4 BC1, BC2 or BC3 block into sixteen RGBA texels.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transaction
//  req_if   in         one compressed block with its block coordinates
//  rsp_if   out        one decoded texel, raster order, last one flagged
//  csr_if   in         one register write (format, image width, height)
//
// Each block produces sixteen texel transactions, one per cycle unless the
// response stalls; the texel counter over the held block sets this rate.
// The next block is accepted in the cycle that its predecessor's last texel
// moves into the output register, so blocks stream without a gap.
// A stalled response holds the output register and the texel counter in place.
// Reset (synchronous, active high) empties both stages and restores the
// registers to BC1 and a 4096 by 4096 image.
//
module bc1_bc2_bc3_block_decoder (
   input  logic        clock,
   input  logic        reset,
   bcdec_req_if.sink   req_if,
   bcdec_rsp_if.source rsp_if,
   bcdec_csr_if.sink   csr_if
);

   // Config regs. Writes must arrive only while the block is idle; unchecked.
   logic [1:0]  format_ff;
   logic [14:0] width_ff;
   logic [14:0] height_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= bcdec_pkg::FMT_BC1;
         width_ff  <= bcdec_pkg::ImageSizeReset;
         height_ff <= bcdec_pkg::ImageSizeReset;
      end else if (csr_if.valid) begin
         unique case (csr_if.data.index)
            bcdec_pkg::CSR_FORMAT_MODE:  format_ff <= csr_if.data.data[1:0];
            bcdec_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_if.data.data;
            bcdec_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_if.data.data;
            default: ;
         endcase
      end
   end

   // Block stage: palette data is worked out while the block is captured.
   bcdec_pkg::pal_type pal_in;
   bcdec_pkg::pal_type pal_ff;
   logic [11:0]        col_ff;
   logic [11:0]        row_ff;
   logic [15:0][1:0]   cidx_ff;   // 2-bit colour index per texel
   logic [15:0][3:0]   xalpha_ff; // BC2 explicit alpha per texel
   logic [15:0][2:0]   aidx_ff;   // BC3 alpha index per texel
   logic               blk_vld_ff;
   logic [3:0]         cnt_ff;

   bcdec_palette u_palette (
      .alpha_word (req_if.data.alpha_word),
      .endpoints  (req_if.data.colour_word[31:0]),
      .punch      (format_ff == bcdec_pkg::FMT_BC1),
      .pal        (pal_in)
   );

   logic rsp_vld_ff;
   logic advance;
   logic last_adv;
   logic req_acc;

   // A texel moves forward when the output register is free or being taken.
   assign advance  = blk_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign last_adv = advance && (cnt_ff == 4'd15);
   assign req_if.ready = !blk_vld_ff || last_adv;
   assign req_acc  = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_vld_ff <= 1'b0;
         cnt_ff     <= 4'd0;
      end else begin
         if (req_acc) begin
            blk_vld_ff <= 1'b1;
         end else if (last_adv) begin
            blk_vld_ff <= 1'b0;
         end
         if (advance) begin
            cnt_ff <= cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         pal_ff    <= pal_in;
         col_ff    <= req_if.data.block_col;
         row_ff    <= req_if.data.block_row;
         cidx_ff   <= req_if.data.colour_word[63:32];
         xalpha_ff <= req_if.data.alpha_word;
         aidx_ff   <= req_if.data.alpha_word[63:16];
      end
   end

   // Texel stage: pick the palette entry for the texel under the counter.
   bcdec_pkg::rsp_type rsp_in;
   bcdec_pkg::rsp_type rsp_ff;
   logic [1:0]         ci;
   logic [2:0][7:0]    rgb;

   assign ci = cidx_ff[cnt_ff];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (ci)
            2'd0: rgb[c] = pal_ff.ep0[c];
            2'd1: rgb[c] = pal_ff.ep1[c];
            2'd2: begin
               if (pal_ff.three_col) begin
                  rgb[c] = 8'((9'(pal_ff.ep0[c]) + 9'(pal_ff.ep1[c])) >> 1);
               end else begin
                  rgb[c] = bcdec_pkg::div3({pal_ff.ep0[c], 1'b0} + 10'(pal_ff.ep1[c]));
               end
            end
            default: begin
               if (pal_ff.three_col) begin
                  rgb[c] = 8'd0;
               end else begin
                  rgb[c] = bcdec_pkg::div3(10'(pal_ff.ep0[c]) + {pal_ff.ep1[c], 1'b0});
               end
            end
         endcase
      end

      rsp_in.texel_x = {col_ff, cnt_ff[1:0]};
      rsp_in.texel_y = {row_ff, cnt_ff[3:2]};
      rsp_in.red     = rgb[0];
      rsp_in.green   = rgb[1];
      rsp_in.blue    = rgb[2];

      // In BC1 only the transparent entry of three-colour mode is not opaque.
      case (format_ff)
         bcdec_pkg::FMT_BC1: begin
            rsp_in.alpha = (pal_ff.three_col && (ci == 2'd3)) ? 8'd0 : 8'd255;
         end
         bcdec_pkg::FMT_BC2: rsp_in.alpha = {xalpha_ff[cnt_ff], xalpha_ff[cnt_ff]};
         default:            rsp_in.alpha = pal_ff.apal[aidx_ff[cnt_ff]];
      endcase

      rsp_in.inside_image = (15'(rsp_in.texel_x) < width_ff) &&
                            (15'(rsp_in.texel_y) < height_ff);
      rsp_in.last_texel   = (cnt_ff == 4'd15);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid = rsp_vld_ff;
   assign rsp_if.data  = rsp_ff;

endmodule
